// ===== sv/text_console_writer_unit_defines.svh =====
// Assertion macros for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("tcw assertion failed");
`define TCW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcw assertion failed");
`define TCW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcw assertion failed");
`else
`define TCW_ASSERT(lbl, cond)
`define TCW_ASSERT_IMP(lbl, ante, cons)
`define TCW_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/tcw_pkg.sv =====
`default_nettype none
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] CR_CODE    = 8'd13;
    localparam logic [7:0] LF_CODE    = 8'd10;
    localparam logic [7:0] BLANK_CODE = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h09;

    typedef struct packed {
        logic        op;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [10:0] cursor_position;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic exec;
        logic clear_wr;
        logic scroll_prime;
        logic scroll_wr;
        logic load_direct;
        logic load_stage;
    } t_cmd;

    typedef struct packed {
        logic need_scroll;
        logic last_ptr;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== sv/tcw_datapath.sv =====
`default_nettype none
`include "text_console_writer_unit_defines.svh"
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    output t_sts            o_sts,
    input  wire t_in_item   i_in_data,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output t_out_item       o_out_data
);

    localparam int TOTAL = COLUMNS * ROWS;
    localparam int AW    = $clog2(TOTAL);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [AW-1:0] LAST_CELL      = AW'(TOTAL - 1);
    localparam logic [AW-1:0] LAST_ROW_START = AW'(TOTAL - COLUMNS);
    localparam logic [AW-1:0] COL_STEP       = AW'(COLUMNS);
    localparam logic [CW-1:0] LAST_COL       = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW       = RW'(ROWS - 1);

    logic [15:0]   mem [TOTAL];
    logic [15:0]   r_rdata;

    logic [7:0]    r_attr;
    logic [AW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [AW-1:0] r_ptr;
    logic          r_op;
    logic [7:0]    r_code;
    logic          r_rd_ok;
    logic [15:0]   r_stage_val;
    logic          r_out_valid;
    t_out_item     r_out_data;

    logic [AW+10:0] w_idx_ext;
    logic           w_idx_ok;
    logic [AW-1:0]  w_idx_addr;
    logic [AW:0]    w_src_next;
    logic [AW-1:0]  w_src_addr;
    logic [AW-1:0]  w_raddr;
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [15:0]    w_wdata;
    logic           w_put;
    logic           w_is_lf;
    logic           w_is_char;
    logic [15:0]    w_res_val;
    logic [AW+10:0] w_cur_ext;
    logic [AW+10:0] w_ncur_ext;

    assign w_idx_ext  = (AW + 11)'(i_in_data.cell_index);
    assign w_idx_ok   = w_idx_ext < (AW + 11)'(TOTAL);
    assign w_idx_addr = w_idx_ok ? w_idx_ext[AW-1:0] : '0;

    assign w_src_next = {1'b0, r_ptr} + (AW + 1)'(COLUMNS + 1);
    assign w_src_addr = (w_src_next < (AW + 1)'(TOTAL)) ? w_src_next[AW-1:0] : '0;

    assign w_raddr = i_cmd.scroll_prime ? COL_STEP :
                     i_cmd.scroll_wr    ? w_src_addr : w_idx_addr;

    assign w_put     = (r_op == OP_PUT) && (r_code != CR_CODE);
    assign w_is_lf   = w_put && (r_code == LF_CODE);
    assign w_is_char = w_put && (r_code != LF_CODE);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr;
        w_wdata = 16'h0000;
        if (i_cmd.exec && w_is_char) begin
            w_we    = 1'b1;
            w_waddr = r_cur;
            w_wdata = {r_attr, r_code};
        end else if (i_cmd.clear_wr) begin
            w_we = 1'b1;
        end else if (i_cmd.scroll_wr) begin
            w_we    = 1'b1;
            w_wdata = (r_ptr < LAST_ROW_START) ? r_rdata : {r_attr, BLANK_CODE};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_comb begin
        n_cur = r_cur;
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.exec && w_is_lf) begin
            n_col = '0;
            if (r_row == LAST_ROW) begin
                n_cur = LAST_ROW_START;
            end else begin
                n_row = r_row + 1'b1;
                n_cur = r_cur - AW'(r_col) + COL_STEP;
            end
        end else if (i_cmd.exec && w_is_char) begin
            if (r_col == LAST_COL) begin
                n_col = '0;
                if (r_row == LAST_ROW) begin
                    n_cur = LAST_ROW_START;
                end else begin
                    n_row = r_row + 1'b1;
                    n_cur = r_cur + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
                n_cur = r_cur + 1'b1;
            end
        end
    end

    assign w_res_val  = ((r_op == OP_READ) && r_rd_ok) ? r_rdata : 16'h0000;
    assign w_cur_ext  = (AW + 11)'(r_cur);
    assign w_ncur_ext = (AW + 11)'(n_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= ATTR_RESET;
            r_cur       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            r_cur <= n_cur;
            r_col <= n_col;
            r_row <= n_row;
            if (i_cmd.clear_wr || i_cmd.scroll_wr) begin
                r_ptr <= (r_ptr == LAST_CELL) ? '0 : r_ptr + 1'b1;
            end
            if (i_cmd.load_direct || i_cmd.load_stage) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_in_data.op;
            r_code  <= i_in_data.char_code;
            r_rd_ok <= w_idx_ok;
        end
        if (i_cmd.exec) begin
            r_stage_val <= w_res_val;
        end
        if (i_cmd.load_direct) begin
            r_out_data.cell_value      <= w_res_val;
            r_out_data.cursor_position <= w_ncur_ext[10:0];
        end else if (i_cmd.load_stage) begin
            r_out_data.cell_value      <= r_stage_val;
            r_out_data.cursor_position <= w_cur_ext[10:0];
        end
    end

    assign o_sts.need_scroll = w_put && (r_row == LAST_ROW) &&
                               ((r_code == LF_CODE) || (r_col == LAST_COL));
    assign o_sts.last_ptr    = (r_ptr == LAST_CELL);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `TCW_ASSERT(a_cur_range, 32'(r_cur) < TOTAL)
    `TCW_ASSERT(a_cur_rowcol, 32'(r_cur) == 32'(r_row) * COLUMNS + 32'(r_col))
    `TCW_ASSERT_IMP(a_load_free, i_cmd.load_direct || i_cmd.load_stage, !r_out_valid || i_out_ready)
    `TCW_ASSERT_NXT(a_scroll_cur, i_cmd.exec && o_sts.need_scroll, r_cur == LAST_ROW_START)

endmodule
`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
`default_nettype none
module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_PRIME,
        S_SCROLL,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.last_ptr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.need_scroll) begin
                    n_state = S_PRIME;
                end else if (i_sts.out_free) begin
                    o_cmd.load_direct = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PRIME: begin
                o_cmd.scroll_prime = 1'b1;
                n_state            = S_SCROLL;
            end
            S_SCROLL: begin
                o_cmd.scroll_wr = 1'b1;
                if (i_sts.last_ptr) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_stage = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

// ===== sv/text_console_writer_unit.sv =====
// An item is accepted in S_IDLE, then executed in S_EXEC on the registered read. For reads
// and puts without a scroll, S_EXEC loads the result register if the output is free, else
// S_DONE waits for it. No new item is accepted until the last result is loaded. A put that
// scrolls goes through S_PRIME and S_SCROLL, one memory write per cell, and S_DONE loads
// its result. A stalled result holds the input until it drains. Reset is synchronous,
// active low; afterwards a clearing pass zeroes the screen, input not ready.
`default_nettype none
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_data,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
